### hdl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define MCSL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mcsl assertion failed");

// next-cycle implication, disabled during reset
`define MCSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mcsl assertion failed");

`endif

### hdl/mcsl_pkg.sv
// package with types, constants and command shaping for the slew limiter
package mcsl_pkg;

    localparam int NUM_CHANNELS_DEF = 10;

    localparam int CHAN_W  = 4;
    localparam int CMD_W   = 10;
    localparam int DRIVE_W = 8;
    localparam int STEP_W  = 8;
    localparam int DB_W    = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 8'sd127;
    localparam logic [STEP_W-1:0] STEP_LIMIT_RST = 8'd15;
    localparam logic [DB_W-1:0]   DEAD_BAND_RST  = 7'd15;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND  = 1'b1;

    localparam logic MODE_SET  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic set_target;
        logic step_load;
        logic step_last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_status;

    // deadband then saturation to the drive range
    function automatic logic signed [DRIVE_W-1:0] shape_command(
        input logic signed [CMD_W-1:0] cmd,
        input logic [DB_W-1:0] dead_band
    );
        logic signed [CMD_W:0] c_ext;
        logic [CMD_W:0] mag;
        logic signed [DRIVE_W-1:0] res;
        c_ext = {cmd[CMD_W-1], cmd};
        mag = c_ext[CMD_W] ? (CMD_W+1)'(-c_ext) : c_ext;
        if (mag < {{(CMD_W+1-DB_W){1'b0}}, dead_band}) begin
            res = '0;
        end else if (cmd > CMD_W'(DRIVE_MAX)) begin
            res = DRIVE_MAX;
        end else if (cmd < -CMD_W'(DRIVE_MAX)) begin
            res = -DRIVE_MAX;
        end else begin
            res = cmd[DRIVE_W-1:0];
        end
        return res;
    endfunction

endpackage

### hdl/mcsl_in_if.sv
// input word channel: set or tick
interface mcsl_in_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [mcsl_pkg::CHAN_W-1:0]  channel;
    logic signed [mcsl_pkg::CMD_W-1:0] command;

    modport source (output valid, output mode, output channel, output command, input ready);
    modport sink   (input valid, input mode, input channel, input command, output ready);
endinterface

### hdl/mcsl_out_if.sv
// output word channel: one channel value per word
interface mcsl_out_if;
    logic                         valid;
    logic                         ready;
    logic [mcsl_pkg::CHAN_W-1:0]  out_channel;
    logic signed [mcsl_pkg::DRIVE_W-1:0] drive_value;
    logic                         last;

    modport source (output valid, output out_channel, output drive_value, output last,
                    input ready);
    modport sink   (input valid, input out_channel, input drive_value, input last,
                    output ready);
endinterface

### hdl/mcsl_ctrl.sv
// controller: accepts words and walks the channels on a tick
`include "assert_macros.svh"

module mcsl_ctrl #(
    parameter int NUM_CHANNELS = mcsl_pkg::NUM_CHANNELS_DEF,
    parameter int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_mode,
    output logic                 o_in_ready,
    input  mcsl_pkg::t_status    i_status,
    output mcsl_pkg::t_cmd       o_cmd,
    output logic [IDX_W-1:0]     o_idx
);
    import mcsl_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

    t_state r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_in_mode == MODE_TICK) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_status.out_free && r_cnt == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and channel counter
    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd.set_target = 1'b0;
        o_cmd.step_load  = 1'b0;
        o_cmd.step_last  = 1'b0;
        n_cnt            = r_cnt;
        case (r_state)
            ST_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.set_target = i_in_valid && (i_in_mode == MODE_SET);
            end
            ST_RUN: begin
                o_cmd.step_load = i_status.out_free;
                o_cmd.step_last = r_cnt == LAST_IDX;
                if (i_status.out_free) begin
                    n_cnt = (r_cnt == LAST_IDX) ? '0 : r_cnt + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_idx = r_cnt;

    `MCSL_ASSERT_NOW(a_idle_cnt_zero, i_clk, i_rst_n, r_state == ST_IDLE, r_cnt == '0)
    `MCSL_ASSERT_NEXT(a_last_to_idle, i_clk, i_rst_n, o_cmd.step_load && o_cmd.step_last, r_state == ST_IDLE)
    `MCSL_ASSERT_NOW(a_no_set_in_run, i_clk, i_rst_n, o_cmd.set_target, !o_cmd.step_load && o_in_ready)

endmodule

### hdl/mcsl_dp.sv
// datapath: config registers, target and current tables, output register
`include "assert_macros.svh"

module mcsl_dp #(
    parameter int NUM_CHANNELS = mcsl_pkg::NUM_CHANNELS_DEF,
    parameter int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mcsl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mcsl_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic [mcsl_pkg::CHAN_W-1:0]         i_channel,
    input  logic signed [mcsl_pkg::CMD_W-1:0]   i_command,
    input  mcsl_pkg::t_cmd                      i_cmd,
    input  logic [IDX_W-1:0]                    i_idx,
    output mcsl_pkg::t_status                   o_status,
    mcsl_out_if.source                          o_out
);
    import mcsl_pkg::*;

    localparam int EXT_W = IDX_W + CHAN_W;

    logic [STEP_W-1:0] r_step_limit;
    logic [DB_W-1:0]   r_dead_band;
    logic signed [DRIVE_W-1:0] r_tgt [NUM_CHANNELS];
    logic signed [DRIVE_W-1:0] r_cur [NUM_CHANNELS];

    logic                      r_out_valid;
    logic [CHAN_W-1:0]         r_out_channel;
    logic signed [DRIVE_W-1:0] r_out_drive;
    logic                      r_out_last;

    logic [EXT_W-1:0]          ch_ext;
    logic [IDX_W-1:0]          set_idx;
    logic                      set_ok;
    logic [EXT_W-1:0]          idx_ext;
    logic signed [DRIVE_W:0]   diff;
    logic [DRIVE_W-1:0]        diff_mag;
    logic [STEP_W-1:0]         step;
    logic signed [DRIVE_W:0]   n_cur_wide;
    logic signed [DRIVE_W-1:0] n_cur;

    // set word: channel range check
    assign ch_ext  = EXT_W'(i_channel);
    assign set_idx = ch_ext[IDX_W-1:0];
    assign set_ok  = ch_ext < EXT_W'(NUM_CHANNELS);

    // slew step for the channel under the counter
    assign diff     = (DRIVE_W+1)'(r_tgt[i_idx]) - (DRIVE_W+1)'(r_cur[i_idx]);
    assign diff_mag = diff[DRIVE_W] ? DRIVE_W'(-diff) : diff[DRIVE_W-1:0];
    assign step     = (diff_mag < r_step_limit) ? diff_mag : r_step_limit;
    always_comb begin
        n_cur_wide = (DRIVE_W+1)'(r_cur[i_idx]);
        if (diff > 0) begin
            n_cur_wide = n_cur_wide + (DRIVE_W+1)'(step);
        end else if (diff < 0) begin
            n_cur_wide = n_cur_wide - (DRIVE_W+1)'(step);
        end
        n_cur = n_cur_wide[DRIVE_W-1:0];
    end

    assign idx_ext = EXT_W'(i_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_limit <= STEP_LIMIT_RST;
            r_dead_band  <= DEAD_BAND_RST;
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_tgt[k] <= '0;
                r_cur[k] <= '0;
            end
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_STEP_LIMIT) begin
                r_step_limit <= i_cfg_wdata[STEP_W-1:0];
            end
            if (i_cfg_we && i_cfg_idx == CFG_DEAD_BAND) begin
                r_dead_band <= i_cfg_wdata[DB_W-1:0];
            end
            if (i_cmd.set_target && set_ok) begin
                r_tgt[set_idx] <= shape_command(i_command, r_dead_band);
            end
            if (i_cmd.step_load) begin
                r_cur[i_idx] <= n_cur;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step_load) begin
            r_out_channel <= idx_ext[CHAN_W-1:0];
            r_out_drive   <= n_cur;
            r_out_last    <= i_cmd.step_last;
        end
    end

    assign o_status.out_free  = !r_out_valid || o_out.ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.out_channel  = r_out_channel;
    assign o_out.drive_value  = r_out_drive;
    assign o_out.last         = r_out_last;

    `MCSL_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, i_cmd.step_load, r_out_valid)
    `MCSL_ASSERT_NOW(a_drive_in_range, i_clk, i_rst_n, r_out_valid, r_out_drive != -DRIVE_MAX - 8'sd1)
    `MCSL_ASSERT_NOW(a_load_only_free, i_clk, i_rst_n, i_cmd.step_load, !r_out_valid || o_out.ready)

endmodule

### hdl/multi_channel_slew_limiter_unit.sv
// top level of the multi-channel slew limiter: controller plus datapath
// a set word is written into the target table when taken; a tick moves the controller to run, and
// each channel word then goes through the output register, one channel per cycle unless the sink holds off;
// the next input word waits for the walk to end
// reset: step_limit and dead_band go to 15, every target and current value to zero
module multi_channel_slew_limiter_unit #(
    parameter int NUM_CHANNELS = mcsl_pkg::NUM_CHANNELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mcsl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mcsl_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    mcsl_in_if.sink                         i_in,
    mcsl_out_if.source                      o_out
);
    import mcsl_pkg::*;

    // counter width, at least one bit for a single channel
    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // command and status between the two halves
    t_cmd             cmd;
    t_status          status;
    logic [IDX_W-1:0] idx;
    logic             in_ready;

    // controller: idle takes words, run walks channels when the output register frees
    mcsl_ctrl #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_mode  (i_in.mode),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_idx      (idx)
    );

    assign i_in.ready = in_ready;

    // datapath: tables, slew step and the output word register
    mcsl_dp #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_channel   (i_in.channel),
        .i_command   (i_in.command),
        .i_cmd       (cmd),
        .i_idx       (idx),
        .o_status    (status),
        .o_out       (o_out)
    );

endmodule

### test/tb.sv
// testbench for the multi-channel slew limiter: random and directed words checked against a predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mcsl_pkg::*;

    localparam int N_CH = NUM_CHANNELS_DEF;

    // one expected output word of a tick
    typedef struct {
        logic [CHAN_W-1:0]         chan;
        logic signed [DRIVE_W-1:0] drive;
        logic                      last;
    } t_drive_word;

    // mirror of the target and current tables plus the queue of drive words still owed
    class slew_tracker;
        logic [STEP_W-1:0]         step_limit;
        logic [DB_W-1:0]           dead_band;
        logic signed [DRIVE_W-1:0] target_tbl[N_CH];
        logic signed [DRIVE_W-1:0] current_tbl[N_CH];
        t_drive_word               drive_queue[$];
        int                        fail_count;

        function new();
            step_limit = STEP_LIMIT_RST;
            dead_band  = DEAD_BAND_RST;
            foreach (target_tbl[i]) begin
                target_tbl[i]  = '0;
                current_tbl[i] = '0;
            end
            fail_count = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_STEP_LIMIT) begin
                step_limit = data[STEP_W-1:0];
            end else begin
                dead_band = data[DB_W-1:0];
            end
        endfunction

        // dead band first, then clamp to the drive range
        function logic signed [DRIVE_W-1:0] shaped(logic signed [CMD_W-1:0] cmd);
            int c;
            int mag;
            c   = cmd;
            mag = (c < 0) ? -c : c;
            if (mag < int'(dead_band)) return '0;
            if (c > int'(DRIVE_MAX)) return DRIVE_MAX;
            if (c < -int'(DRIVE_MAX)) return -DRIVE_MAX;
            return cmd[DRIVE_W-1:0];
        endfunction

        function void note_word(logic mode, logic [CHAN_W-1:0] chan,
                                logic signed [CMD_W-1:0] cmd);
            int          diff;
            int          mag;
            int          stp;
            t_drive_word w;
            if (mode == MODE_SET) begin
                if (chan < N_CH) target_tbl[chan] = shaped(cmd);
                return;
            end
            for (int i = 0; i < N_CH; i++) begin
                diff = int'(target_tbl[i]) - int'(current_tbl[i]);
                mag  = (diff < 0) ? -diff : diff;
                stp  = (mag < int'(step_limit)) ? mag : int'(step_limit);
                if (diff > 0) begin
                    current_tbl[i] = DRIVE_W'(int'(current_tbl[i]) + stp);
                end else if (diff < 0) begin
                    current_tbl[i] = DRIVE_W'(int'(current_tbl[i]) - stp);
                end
                w.chan  = CHAN_W'(i);
                w.drive = current_tbl[i];
                w.last  = (i == N_CH - 1);
                drive_queue.push_back(w);
            end
        endfunction

        function void check_drive(logic [CHAN_W-1:0] chan, logic signed [DRIVE_W-1:0] drive,
                                  logic last);
            t_drive_word w;
            if (drive_queue.size() == 0) begin
                $error("unexpected word: out_channel %0d drive_value %0d last %0b",
                       chan, drive, last);
                fail_count++;
                return;
            end
            w = drive_queue.pop_front();
            if (chan !== w.chan) begin
                $error("out_channel: expected %0d, got %0d", w.chan, chan);
                fail_count++;
            end
            if (drive !== w.drive) begin
                $error("drive_value: expected %0d, got %0d", w.drive, drive);
                fail_count++;
            end
            if (last !== w.last) begin
                $error("last: expected %0b, got %0b", w.last, last);
                fail_count++;
            end
        endfunction

        function int pending();
            return drive_queue.size();
        endfunction

        function void flag_leftover();
            if (drive_queue.size() != 0) begin
                $error("%0d expected words never arrived", drive_queue.size());
                fail_count++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    mcsl_in_if  in_if ();
    mcsl_out_if out_if ();

    slew_tracker tracker;

    // when set, neither side inserts idle cycles
    bit quiet;

    multi_channel_slew_limiter_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always #5 i_clk = ~i_clk;

    // output side: check every accepted word, outside quiet phases drop ready about 8 times in 100
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            tracker.check_drive(out_if.out_channel, out_if.drive_value, out_if.last);
        end
        out_if.ready <= quiet || ($urandom_range(99) >= 8);
    end

    // present one input word, maybe after a short gap, and hold it until taken
    task automatic send_word(input logic mode, input logic [CHAN_W-1:0] chan,
                             input logic signed [CMD_W-1:0] cmd);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(99) < 8) gap = $urandom_range(1, 5);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.mode    <= mode;
        in_if.channel <= chan;
        in_if.command <= cmd;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        tracker.note_word(mode, chan, cmd);
    endtask

    // ticks carry random junk in the unused fields
    task automatic send_tick();
        send_word(MODE_TICK, CHAN_W'($urandom), CMD_W'($urandom));
    endtask

    // stop sending, wait for every owed word, then give a set still in flight time to land
    task automatic drain_drives();
        in_if.valid <= 1'b0;
        while (tracker.pending() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // both registers back to back, write enable held across both writes
    task automatic set_limits(input logic [CFG_DATA_W-1:0] step,
                              input logic [CFG_DATA_W-1:0] band);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_STEP_LIMIT;
        i_cfg_wdata <= step;
        @(posedge i_clk);
        tracker.set_reg(CFG_STEP_LIMIT, step);
        i_cfg_idx   <= CFG_DEAD_BAND;
        i_cfg_wdata <= band;
        @(posedge i_clk);
        tracker.set_reg(CFG_DEAD_BAND, band);
        i_cfg_we    <= 1'b0;
    endtask

    // mostly sets to real channels, some ticks, a few sets to channels that do not exist
    task automatic send_random();
        logic [CHAN_W-1:0]         chan;
        logic signed [CMD_W-1:0]   cmd;
        int                        off;
        if ($urandom_range(99) < 30) begin
            send_tick();
            return;
        end
        if ($urandom_range(99) < 90) begin
            chan = CHAN_W'($urandom_range(N_CH - 1));
        end else begin
            chan = CHAN_W'($urandom_range(15, N_CH));
        end
        case ($urandom_range(3))
            0: cmd = CMD_W'($urandom);
            // hover around the dead band edge
            1: begin
                off = int'(tracker.dead_band) + int'($urandom_range(4)) - 2;
                cmd = CMD_W'(($urandom_range(1) == 1) ? off : -off);
            end
            // around the saturation edge
            2: cmd = CMD_W'(int'($urandom_range(260)) - 130);
            default: begin
                case ($urandom_range(5))
                    0: cmd = -CMD_W'(512);
                    1: cmd = CMD_W'(511);
                    2: cmd = CMD_W'(127);
                    3: cmd = -CMD_W'(127);
                    4: cmd = CMD_W'(128);
                    default: cmd = -CMD_W'(128);
                endcase
            end
        endcase
        send_word(MODE_SET, chan, cmd);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_STEP_LIMIT;
        i_cfg_wdata   = '0;
        in_if.valid   = 1'b0;
        in_if.mode    = MODE_SET;
        in_if.channel = '0;
        in_if.command = '0;
        quiet         = 1'b0;
        tracker       = new();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset limits: saturation both ways, dead band edges, ignored channels
        send_word(MODE_SET, 4'd0, 10'sd511);
        send_word(MODE_SET, 4'd1, -10'sd512);
        send_word(MODE_SET, 4'd2, 10'sd14);
        send_word(MODE_SET, 4'd3, -10'sd14);
        send_word(MODE_SET, 4'd4, 10'sd15);
        send_word(MODE_SET, 4'd5, -10'sd15);
        send_word(MODE_SET, 4'd6, 10'sd127);
        send_word(MODE_SET, 4'd7, -10'sd127);
        send_word(MODE_SET, 4'd8, 10'sd128);
        send_word(MODE_SET, 4'd9, -10'sd128);
        send_word(MODE_SET, 4'd10, 10'sd77);
        send_word(MODE_SET, 4'd15, -10'sd300);
        send_tick();
        send_tick();
        send_tick();
        // reverse a channel mid-walk; channels already at target must sit still
        send_word(MODE_SET, 4'd0, 10'sd0);
        send_tick();
        send_tick();

        // widest step, no dead band: full swing in one tick, tiny commands survive
        drain_drives();
        set_limits(8'd255, 8'd0);
        send_word(MODE_SET, 4'd2, 10'sd1);
        send_word(MODE_SET, 4'd1, 10'sd127);
        send_word(MODE_SET, 4'd7, 10'sd127);
        send_tick();

        // zero step: nothing moves but all words still come; widest dead band
        drain_drives();
        set_limits(8'd0, 8'd127);
        send_word(MODE_SET, 4'd0, 10'sd126);
        send_word(MODE_SET, 4'd3, -10'sd127);
        send_tick();

        // random phases, each with its own limits; the middle one runs without idling
        for (int phase = 0; phase < 5; phase++) begin
            drain_drives();
            case (phase)
                0: set_limits(CFG_DATA_W'($urandom_range(30, 2)),
                              CFG_DATA_W'($urandom_range(127)));
                1: set_limits(8'd255, 8'd0);
                2: set_limits(CFG_DATA_W'($urandom_range(255, 128)),
                              CFG_DATA_W'($urandom_range(127)));
                3: set_limits(8'd1, 8'd127);
                default: set_limits(8'd0, CFG_DATA_W'($urandom_range(127)));
            endcase
            quiet = (phase == 2);
            for (int n = 0; n < 71; n++) begin
                send_random();
            end
        end
        quiet = 1'b0;

        drain_drives();
        repeat (20) @(posedge i_clk);
        tracker.flag_leftover();
        if (tracker.fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial begin
        #5ms;
        $display("tb failed");
        $finish;
    end

endmodule
